FILE: rtl/rgt_pkg.sv
// Report group table: shared types and constants.
// Item and result words, operation and status codes, controller states and
// the command/status groups between controller and datapath. No dependencies.
package rgt_pkg;

  // Fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned ATYPE_W    = 3;
  localparam int unsigned ADDR_W     = 64;
  localparam int unsigned ADDR_BYTES = 16;  // bytes of address compared
  localparam int unsigned KEY_W      = ATYPE_W + 8 * ADDR_BYTES;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned GIDX_W     = 5;
  localparam int unsigned SLOT_W     = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ADD_SPECIAL = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_NORMAL  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR       = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_GROUP_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_ADDRESS = 2'd3;

  localparam logic [ATYPE_W-1:0] ATYPE_NONE = 3'd0;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [ID_W-1:0]    context_id;
    logic [ATYPE_W-1:0] addr_type;
    logic [ADDR_W-1:0]  dest_addr_high;
    logic [ADDR_W-1:0]  dest_addr_low;
  } rgt_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [GIDX_W-1:0] group_index;
    logic [SLOT_W-1:0] member_slot;
    logic              new_group;
  } rgt_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_PROBE,
    S_CMP
  } rgt_state_e;

  // Finishing actions the datapath carries out
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_NOADDR,
    ACT_NORMAL,
    ACT_CLEAR,
    ACT_PLAIN_OK,
    ACT_CLAIM,
    ACT_JOIN,
    ACT_TFULL
  } rgt_act_e;

  typedef struct packed {
    logic     capture;  // latch the input word
    logic     g_init;   // scan pointer to group 1
    logic     g_inc;    // scan pointer to next group
    logic     rd_en;    // read group entry at scan pointer
    rgt_act_e act;
  } rgt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            type_zero;
    logic            g_valid;
    logic            match;
    logic            g_last;
  } rgt_stat_t;

endpackage

FILE: rtl/rgt_ctrl.sv
// Report group table controller: decodes the latched word and steps the
// group scan. Depends on rgt_pkg.
module rgt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rgt_pkg::rgt_stat_t stat_i,
  output rgt_pkg::rgt_cmd_t  cmd_o
);
  import rgt_pkg::*;

  rgt_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '{capture: 1'b0, g_init: 1'b0, g_inc: 1'b0, rd_en: 1'b0, act: ACT_NONE};
    busy    = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (stat_i.op)
          OP_ADD_SPECIAL: begin
            if (stat_i.type_zero) begin
              cmd_o.act = ACT_NOADDR;
            end else begin
              cmd_o.g_init = 1'b1;
              state_d      = S_PROBE;
            end
          end
          OP_ADD_NORMAL: cmd_o.act = ACT_NORMAL;
          OP_CLEAR:      cmd_o.act = ACT_CLEAR;
          default:       cmd_o.act = ACT_PLAIN_OK;
        endcase
      end
      // free group claims at once, a valid one is read for compare
      S_PROBE: begin
        if (!stat_i.g_valid) begin
          cmd_o.act = ACT_CLAIM;
          state_d   = S_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_CMP;
        end
      end
      S_CMP: begin
        if (stat_i.match) begin
          cmd_o.act = ACT_JOIN;
          state_d   = S_IDLE;
        end else if (stat_i.g_last) begin
          cmd_o.act = ACT_TFULL;
          state_d   = S_IDLE;
        end else begin
          cmd_o.g_inc = 1'b1;
          state_d     = S_PROBE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/rgt_dp.sv
// Report group table datapath: latched word, scan pointer, group valid bits,
// group entry memory, member id memory and result register. Depends on rgt_pkg.
module rgt_dp #(
  parameter int unsigned NUM_GROUPS        = 32,
  parameter int unsigned MEMBERS_PER_GROUP = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rgt_pkg::rgt_item_t   item_i,
  input  rgt_pkg::rgt_cmd_t    cmd_i,
  output rgt_pkg::rgt_stat_t   stat_o,
  output logic                 done_o,
  output rgt_pkg::rgt_result_t result_o
);
  import rgt_pkg::*;

  localparam int unsigned GW = $clog2(NUM_GROUPS);
  localparam int unsigned CW = $clog2(MEMBERS_PER_GROUP + 1);
  localparam int unsigned SW = (MEMBERS_PER_GROUP > 1) ? $clog2(MEMBERS_PER_GROUP) : 1;
  localparam int unsigned EW = KEY_W + CW;
  localparam logic [GW-1:0] G_FIRST = GW'(1);
  localparam logic [GW-1:0] G_LAST  = GW'(NUM_GROUPS - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MEMBERS_PER_GROUP);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  rgt_item_t        item_q;
  logic [GW-1:0]    g_q, g_d;
  logic [NUM_GROUPS-1:0] valid_q, valid_d;
  logic [CW-1:0]    cnt0_q, cnt0_d;
  logic [EW-1:0]    rd_q;
  rgt_result_t      res_q, res_d;
  logic             done_q, done_d;

  // entry: {type, addr high, addr low, member count}
  logic [EW-1:0]    ent_mem [NUM_GROUPS];
  logic [ID_W-1:0]  mid_mem [NUM_GROUPS][MEMBERS_PER_GROUP];

  logic             ent_we;
  logic [EW-1:0]    ent_wdata;
  logic             mid_we;
  logic [GW-1:0]    mid_g;
  logic [SW-1:0]    mid_s;

  logic [KEY_W-1:0] key_in, rd_key;
  logic [CW-1:0]    rd_cnt, rd_cnt_inc, cnt0_inc;
  logic [GW+GIDX_W-1:0] g_ext;
  logic [CW+SLOT_W-1:0] rd_cnt_ext, cnt0_ext;
  logic [GIDX_W-1:0] g_out;
  logic [SLOT_W-1:0] rd_slot_out, cnt0_slot_out;

  assign key_in     = {item_q.addr_type, item_q.dest_addr_high, item_q.dest_addr_low};
  assign rd_key     = rd_q[EW-1:CW];
  assign rd_cnt     = rd_q[CW-1:0];
  assign rd_cnt_inc = rd_cnt + CNT_ONE;
  assign cnt0_inc   = cnt0_q + CNT_ONE;

  // result field forms of the group and slot numbers
  assign g_ext         = {{GIDX_W{1'b0}}, g_q};
  assign g_out         = g_ext[GIDX_W-1:0];
  assign rd_cnt_ext    = {{SLOT_W{1'b0}}, rd_cnt};
  assign rd_slot_out   = rd_cnt_ext[SLOT_W-1:0];
  assign cnt0_ext      = {{SLOT_W{1'b0}}, cnt0_q};
  assign cnt0_slot_out = cnt0_ext[SLOT_W-1:0];

  // status to controller
  assign stat_o.op        = item_q.operation;
  assign stat_o.type_zero = (item_q.addr_type == ATYPE_NONE);
  assign stat_o.g_valid   = valid_q[g_q];
  assign stat_o.match     = (rd_key == key_in);
  assign stat_o.g_last    = (g_q == G_LAST);

  // actions: state updates and result word
  always_comb begin
    g_d       = g_q;
    valid_d   = valid_q;
    cnt0_d    = cnt0_q;
    res_d     = res_q;
    done_d    = 1'b0;
    ent_we    = 1'b0;
    ent_wdata = {key_in, CNT_ONE};
    mid_we    = 1'b0;
    mid_g     = g_q;
    mid_s     = '0;
    if (cmd_i.g_init) begin
      g_d = G_FIRST;
    end else if (cmd_i.g_inc) begin
      g_d = g_q + G_FIRST;
    end
    case (cmd_i.act)
      ACT_NONE: ;
      ACT_NOADDR: begin
        done_d = 1'b1;
        res_d  = '{status: ST_NO_ADDRESS, group_index: '0, member_slot: '0, new_group: 1'b0};
      end
      ACT_NORMAL: begin
        done_d = 1'b1;
        if (cnt0_q < CNT_MAX) begin
          cnt0_d = cnt0_inc;
          mid_we = 1'b1;
          mid_g  = '0;
          mid_s  = cnt0_q[SW-1:0];
          res_d  = '{status: ST_OK, group_index: '0, member_slot: cnt0_slot_out,
                     new_group: 1'b0};
        end else begin
          res_d = '{status: ST_GROUP_FULL, group_index: '0, member_slot: '0, new_group: 1'b0};
        end
      end
      ACT_CLEAR: begin
        done_d  = 1'b1;
        valid_d = '0;
        cnt0_d  = '0;
        res_d   = '{status: ST_OK, group_index: '0, member_slot: '0, new_group: 1'b0};
      end
      ACT_PLAIN_OK: begin
        done_d = 1'b1;
        res_d  = '{status: ST_OK, group_index: '0, member_slot: '0, new_group: 1'b0};
      end
      ACT_CLAIM: begin
        done_d       = 1'b1;
        valid_d[g_q] = 1'b1;
        ent_we       = 1'b1;
        mid_we       = 1'b1;
        res_d        = '{status: ST_OK, group_index: g_out, member_slot: '0, new_group: 1'b1};
      end
      ACT_JOIN: begin
        done_d = 1'b1;
        if (rd_cnt < CNT_MAX) begin
          ent_we    = 1'b1;
          ent_wdata = {rd_key, rd_cnt_inc};
          mid_we    = 1'b1;
          mid_s     = rd_cnt[SW-1:0];
          res_d     = '{status: ST_OK, group_index: g_out, member_slot: rd_slot_out,
                        new_group: 1'b0};
        end else begin
          res_d = '{status: ST_GROUP_FULL, group_index: g_out, member_slot: '0,
                    new_group: 1'b0};
        end
      end
      ACT_TFULL: begin
        done_d = 1'b1;
        res_d  = '{status: ST_TABLE_FULL, group_index: '0, member_slot: '0, new_group: 1'b0};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cnt0_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cnt0_q  <= cnt0_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    g_q   <= g_d;
    res_q <= res_d;
  end

  // group entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[g_q] <= ent_wdata;
    end
    if (cmd_i.rd_en) begin
      rd_q <= ent_mem[g_q];
    end
  end

  // member id memory
  always_ff @(posedge clk_i) begin
    if (mid_we) begin
      mid_mem[mid_g][mid_s] <= item_q.context_id;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: rtl/report_group_table.sv
// Report group table, top level: controller plus datapath.
// Depends on rgt_pkg, rgt_ctrl and rgt_dp.
//
// Usage:
//   A word on item_i is taken at a rising edge where start is high and busy
//   is low. Operations: add to a special group by (type, address), add to
//   the normal group 0, clear the table.
//   Each word gives one result on result_o, marked by done_o for exactly
//   one cycle. The receiver cannot hold it off; results come in order.
// Sequencing:
//   Add normal, clear, no-address and unused codes: the word is decoded and
//   the result registered; no new word is taken until busy falls.
//   Add special: groups are visited from 1 upward; each valid group has its
//   entry read, then compared. A free group is claimed, a matching one is
//   joined; a scan that passes group NUM_GROUPS-1 with no match gives
//   table full. busy stays high while the scan runs.
// Reset:
//   All groups become invalid and the normal group empty at once; no
//   clearing pass is needed, the block takes a word right after reset.
module report_group_table #(
  parameter int unsigned NUM_GROUPS        = 32,
  parameter int unsigned MEMBERS_PER_GROUP = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rgt_pkg::rgt_item_t   item_i,
  output logic                 done_o,
  output rgt_pkg::rgt_result_t result_o
);
  import rgt_pkg::*;

  rgt_cmd_t  cmd;
  rgt_stat_t stat;

  rgt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  rgt_dp #(
    .NUM_GROUPS        (NUM_GROUPS),
    .MEMBERS_PER_GROUP (MEMBERS_PER_GROUP)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

FILE: verif/report_group_table_checker.sv
// Scoreboard for the report group table: mirrors the group table, predicts
// each result from the accepted words and compares it with done_o/result_o.
// Depends on rgt_pkg only.
module report_group_table_checker #(
  parameter int unsigned NUM_GROUPS        = 32,
  parameter int unsigned MEMBERS_PER_GROUP = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  rgt_pkg::rgt_item_t   item_i,
  input  logic                 done_i,
  input  rgt_pkg::rgt_result_t result_i,
  output int unsigned          mismatch_o,
  output int unsigned          pending_o,
  output int unsigned          ok_o,
  output int unsigned          group_full_o,
  output int unsigned          table_full_o,
  output int unsigned          no_addr_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rgt_pkg::*;

  // Shadow copy of the group table
  logic               grp_live [NUM_GROUPS];
  logic [ATYPE_W-1:0] grp_type [NUM_GROUPS];
  logic [ADDR_W-1:0]  grp_hi   [NUM_GROUPS];
  logic [ADDR_W-1:0]  grp_lo   [NUM_GROUPS];
  int unsigned        grp_fill [NUM_GROUPS];

  rgt_result_t placement_q[$];  // predicted placements, oldest first
  int unsigned miss_cnt;
  int unsigned status_hits [4];

  function automatic void wipe_groups();
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_live[g] = 1'b0;
      grp_fill[g] = 0;
    end
  endfunction

  // Apply one word to the shadow table and return the placement it yields
  function automatic rgt_result_t place_context(input rgt_item_t w);
    rgt_result_t r;
    r = '0;
    case (w.operation)
      OP_ADD_SPECIAL: begin
        if (w.addr_type == ATYPE_NONE) begin
          r.status = ST_NO_ADDRESS;
          return r;
        end
        // first matching group or first free group, whichever comes first
        for (int g = 1; g < NUM_GROUPS; g++) begin
          if (grp_live[g] && grp_type[g] == w.addr_type &&
              grp_hi[g] == w.dest_addr_high && grp_lo[g] == w.dest_addr_low) begin
            r.group_index = GIDX_W'(g);
            if (grp_fill[g] < MEMBERS_PER_GROUP) begin
              r.member_slot = SLOT_W'(grp_fill[g]);
              grp_fill[g]++;
            end else begin
              r.status = ST_GROUP_FULL;
            end
            return r;
          end
          if (!grp_live[g]) begin
            grp_live[g]   = 1'b1;
            grp_type[g]   = w.addr_type;
            grp_hi[g]     = w.dest_addr_high;
            grp_lo[g]     = w.dest_addr_low;
            grp_fill[g]   = 1;
            r.group_index = GIDX_W'(g);
            r.new_group   = 1'b1;
            return r;
          end
        end
        r.status = ST_TABLE_FULL;
      end
      OP_ADD_NORMAL: begin
        if (grp_fill[0] < MEMBERS_PER_GROUP) begin
          r.member_slot = SLOT_W'(grp_fill[0]);
          grp_fill[0]++;
        end else begin
          r.status = ST_GROUP_FULL;
        end
      end
      OP_CLEAR: wipe_groups();
      default: ;  // unused code: table untouched, plain ok
    endcase
    return r;
  endfunction

  // Results first (they belong to older words), then the newly accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    rgt_result_t want;
    if (!rst_ni) begin
      wipe_groups();
      placement_q.delete();
      miss_cnt = 0;
      for (int s = 0; s < 4; s++) status_hits[s] = 0;
      mismatch_o   <= 0;
      pending_o    <= 0;
      ok_o         <= 0;
      group_full_o <= 0;
      table_full_o <= 0;
      no_addr_o    <= 0;
    end else begin
      if (done_i) begin
        if (placement_q.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("%t: result with nothing outstanding: status %0d group %0d slot %0d new %0b",
                     $realtime, result_i.status, result_i.group_index,
                     result_i.member_slot, result_i.new_group);
        end else begin
          want = placement_q.pop_front();
          status_hits[want.status]++;
          if (result_i.status !== want.status || result_i.group_index !== want.group_index ||
              result_i.member_slot !== want.member_slot ||
              result_i.new_group !== want.new_group) begin
            miss_cnt++;
            if (miss_cnt <= 10)
              $display("%t: mismatch status %0d/%0d group %0d/%0d slot %0d/%0d new %0b/%0b (exp/got)",
                       $realtime, want.status, result_i.status, want.group_index,
                       result_i.group_index, want.member_slot, result_i.member_slot,
                       want.new_group, result_i.new_group);
          end
        end
      end
      if (start_i && !busy_i) placement_q.push_back(place_context(item_i));
      mismatch_o   <= miss_cnt;
      pending_o    <= placement_q.size();
      ok_o         <= status_hits[ST_OK];
      group_full_o <= status_hits[ST_GROUP_FULL];
      table_full_o <= status_hits[ST_TABLE_FULL];
      no_addr_o    <= status_hits[ST_NO_ADDRESS];
    end
  end

endmodule

FILE: verif/report_group_table_tb.sv
// Top-level bench for report_group_table: drives directed and random words
// under three pacing phases and reports the verdict.
// Depends on rgt_pkg, report_group_table and report_group_table_checker.
module report_group_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgt_pkg::*;

  localparam int unsigned NUM_GROUPS        = 32;
  localparam int unsigned MEMBERS_PER_GROUP = 10;
  localparam int unsigned RUN_LIMIT         = 500000;
  localparam int unsigned POOL_SIZE         = 40;
  localparam int unsigned PHASE_WORDS       = 170;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  logic        busy;
  rgt_item_t   item_i = '0;
  logic        done_o;
  rgt_result_t result_o;

  int unsigned mismatches, pending, n_ok, n_gfull, n_tfull, n_noaddr;
  int unsigned words_sent = 0;
  int unsigned directed_words;
  int unsigned cycle_cnt = 0;
  rgt_item_t   key_pool [POOL_SIZE];

  always #2 clk_i = ~clk_i;

  report_group_table #(
    .NUM_GROUPS        (NUM_GROUPS),
    .MEMBERS_PER_GROUP (MEMBERS_PER_GROUP)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  report_group_table_checker #(
    .NUM_GROUPS        (NUM_GROUPS),
    .MEMBERS_PER_GROUP (MEMBERS_PER_GROUP)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .mismatch_o   (mismatches),
    .pending_o    (pending),
    .ok_o         (n_ok),
    .group_full_o (n_gfull),
    .table_full_o (n_tfull),
    .no_addr_o    (n_noaddr)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic rgt_item_t mk_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                        input logic [ATYPE_W-1:0] atype,
                                        input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo);
    rgt_item_t w;
    w.operation      = op;
    w.context_id     = id;
    w.addr_type      = atype;
    w.dest_addr_high = hi;
    w.dest_addr_low  = lo;
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // Mostly special adds over a reused key pool so groups fill and the table
  // runs out; one hot key overflows its group; clears are rare.
  function automatic rgt_item_t random_word();
    rgt_item_t   w;
    int unsigned pick;
    int unsigned keysel;
    w = mk_word(OP_ADD_SPECIAL, ID_W'($urandom), ATYPE_W'($urandom), rand_addr(), rand_addr());
    pick = $urandom_range(99);
    if (pick < 62) begin
      keysel = $urandom_range(99);
      if (keysel < 80) begin
        w = key_pool[(keysel < 25) ? 0 : $urandom_range(POOL_SIZE - 1)];
        w.context_id = ID_W'($urandom);
      end
    end else if (pick < 80) begin
      w.operation = OP_ADD_NORMAL;
    end else if (pick < 81) begin
      w.operation = OP_CLEAR;
    end else if (pick < 85) begin
      w.operation = OP_UNUSED;
    end else begin
      w.addr_type = ATYPE_NONE;
    end
    return w;
  endfunction

  // Offer one word, idling first at the given rate, and hold it until taken
  task automatic send_word(input rgt_item_t w, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  // Hold off until every outstanding result has come back
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    // key pool: some entries share an address under another type
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = mk_word(OP_ADD_SPECIAL, '0, ATYPE_W'($urandom_range(7, 1)),
                            rand_addr(), rand_addr());
      if (i % 4 == 3) begin
        key_pool[i].dest_addr_high = key_pool[i-1].dest_addr_high;
        key_pool[i].dest_addr_low  = key_pool[i-1].dest_addr_low;
        key_pool[i].addr_type      = (key_pool[i-1].addr_type == 3'd7) ? 3'd1
                                     : key_pool[i-1].addr_type + 3'd1;
      end
    end
    key_pool[1].dest_addr_high = '0;
    key_pool[1].dest_addr_low  = '0;
    key_pool[2].dest_addr_high = '1;
    key_pool[2].dest_addr_low  = '1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: no address, unused code, normal group overflow, claim/join,
    // keys differing in type only or address only, clear and reuse
    send_word(mk_word(OP_ADD_SPECIAL, '1, ATYPE_NONE, '1, '1), 0);
    send_word(mk_word(OP_UNUSED, '1, '1, '1, '1), 0);
    for (int i = 0; i <= MEMBERS_PER_GROUP; i++)
      send_word(mk_word(OP_ADD_NORMAL, (i % 2) ? '1 : ID_W'($urandom), '0, '0, '0), 0);
    send_word(mk_word(OP_ADD_SPECIAL, '0, 3'd7, '1, '1), 0);
    send_word(mk_word(OP_ADD_SPECIAL, '1, 3'd7, '1, '1), 0);
    send_word(mk_word(OP_ADD_SPECIAL, 16'h1234, 3'd4, '1, '1), 0);
    send_word(mk_word(OP_ADD_SPECIAL, 16'h8000, 3'd7, '0, '0), 0);
    send_word(mk_word(OP_ADD_SPECIAL, 16'h0001, 3'd6, '0, 64'd1), 0);
    send_word(mk_word(OP_CLEAR, '1, '1, '1, '1), 0);
    send_word(mk_word(OP_ADD_SPECIAL, 16'h00ff, 3'd7, '1, '1), 0);
    send_word(mk_word(OP_ADD_NORMAL, 16'hff00, '1, '0, '1), 0);
    directed_words = words_sent;
    settle();

    // Random: sender idles 33%, then 83%, then never
    for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word(), 33);
    settle();
    for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word(), 83);
    settle();
    for (int i = 0; i < PHASE_WORDS; i++) send_word(random_word(), 0);
    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words (%0d directed) over three pacing phases with settle pauses.",
             words_sent, directed_words);
    $display("Results by status: ok %0d, group full %0d, table full %0d, no address %0d.",
             n_ok, n_gfull, n_tfull, n_noaddr);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
